// ===== rtl/sefu_pkg.sv =====
// Shared types, constants and register codes for the shared exponent float unpacker.
package sefu_pkg;

  localparam logic [11:0] MAGIC_CODE = 12'hEFF;
  localparam logic [23:0] MAG_LIMIT  = 24'hFFFFFF;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    CFG_HEADER  = 2'd0,
    CFG_MINIMUM = 2'd1,
    CFG_COUNT   = 2'd2,
    CFG_NONE    = 2'd3
  } cfg_idx_e;

  // live configuration; the user keeps it static while items are in flight, the block does not enforce it
  typedef struct packed {
    logic [31:0]        header_word;
    logic signed [24:0] minimum_mantissa;
  } cfg_t;

  // one queued stream word with its classification
  typedef struct packed {
    logic [31:0] word;
    logic        two;    // both tokens produce values
    logic        last0;  // first token ends the block
    logic        last1;  // second token ends the block
  } entry_t;

  function automatic logic [4:0] msb_index(input logic [23:0] v);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction

endpackage

// ===== rtl/sefu_front.sv =====
// Front end: configuration registers, block counter and item classification.
module sefu_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [31:0]          stream_word,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 q_full,
  output logic                 q_push,
  output sefu_pkg::entry_t     q_entry,
  output sefu_pkg::cfg_t       cfg
);

  logic [30:0] point_count;
  logic [30:0] values_done;
  logic [30:0] values_done_next;
  logic [30:0] remaining;
  logic        has_any;
  logic        has_two;
  logic        accept;
  logic        cfg_we;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign cfg_we    = cfg_valid && cfg_ready;

  // values_done never passes point_count, so this never wraps
  assign remaining = point_count - values_done;
  assign has_any   = remaining != 31'd0;
  assign has_two   = remaining[30:1] != 30'd0;

  assign q_push        = accept && has_any;
  assign q_entry.word  = stream_word;
  assign q_entry.two   = has_two;
  assign q_entry.last0 = remaining == 31'd1;
  assign q_entry.last1 = remaining == 31'd2;

  always_comb begin
    values_done_next = values_done;
    if (cfg_we && sefu_pkg::cfg_idx_e'(cfg_index) != sefu_pkg::CFG_NONE) begin
      values_done_next = 31'd0;
    end else if (q_push) begin
      values_done_next = values_done + (has_two ? 31'd2 : 31'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      values_done          <= 31'd0;
      point_count          <= 31'd0;
      cfg.header_word      <= 32'd0;
      cfg.minimum_mantissa <= 25'sd0;
    end else begin
      values_done <= values_done_next;
      if (cfg_we) begin
        unique case (sefu_pkg::cfg_idx_e'(cfg_index))
          sefu_pkg::CFG_HEADER:  cfg.header_word      <= cfg_data;
          sefu_pkg::CFG_MINIMUM: cfg.minimum_mantissa <= $signed(cfg_data[24:0]);
          sefu_pkg::CFG_COUNT:   point_count          <= cfg_data[30:0];
          sefu_pkg::CFG_NONE:    ;
        endcase
      end
    end
  end

  no_push_past_count: assert property (@(posedge clk) disable iff (rst)
    values_done <= point_count) else $error("values_done passed point_count");

  push_needs_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full) else $error("push into full queue");

  count_advance: assert property (@(posedge clk) disable iff (rst)
    (q_push && !cfg_we) |=> values_done == $past(values_done) + ($past(has_two) ? 31'd2 : 31'd1))
    else $error("block counter advanced wrong");

endmodule

// ===== rtl/sefu_fifo.sv =====
// Short queue of classified stream words between the front and back ends.
module sefu_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sefu_pkg::entry_t push_entry,
  input  logic             pop,
  output sefu_pkg::entry_t head,
  output logic             head_valid,
  output logic             full
);

  localparam logic [sefu_pkg::FIFO_AW:0] DEPTH_CNT = (sefu_pkg::FIFO_AW + 1)'(sefu_pkg::FIFO_DEPTH);

  sefu_pkg::entry_t             mem [sefu_pkg::FIFO_DEPTH];
  logic [sefu_pkg::FIFO_AW-1:0] wr_ptr;
  logic [sefu_pkg::FIFO_AW-1:0] rd_ptr;
  logic [sefu_pkg::FIFO_AW:0]   count;
  logic                         do_push;
  logic                         do_pop;

  assign head       = mem[rd_ptr];
  assign head_valid = count != '0;
  assign full       = count == DEPTH_CNT;
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/sefu_back.sv =====
// Back end: per-token mantissa rebuild and IEEE single assembly, four stage pipeline.
module sefu_back (
  input  logic             clk,
  input  logic             rst,
  input  sefu_pkg::cfg_t   cfg,
  input  sefu_pkg::entry_t head,
  input  logic             head_valid,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      value_bits,
  output logic             last_value,
  output logic             header_bad,
  output logic [4:0]       token_bits
);

  logic        en;
  logic        half;
  logic        issue;
  logic [15:0] token;
  logic        tok_last;
  logic        hdr_bad;
  logic        kill;
  logic [7:0]  expo;
  logic [7:0]  shift;

  // stage 1: scaled sum
  logic [40:0]        wide;
  logic               big_c;
  logic signed [27:0] sum_c;
  logic               s1_valid;
  logic               s1_last;
  logic               s1_big;
  logic signed [27:0] s1_sum;

  // stage 2: sign and saturated magnitude
  logic               neg;
  logic [27:0]        absv;
  logic               s2_valid;
  logic               s2_last;
  logic               s2_sign;
  logic [23:0]        s2_mag;

  // stage 3: leading one position
  logic               s3_valid;
  logic               s3_last;
  logic               s3_sign;
  logic [23:0]        s3_mag;
  logic [4:0]         s3_p;

  // output assembly
  logic [8:0]         e9;
  logic [23:0]        norm;
  logic [31:0]        sub;
  logic [4:0]         sub_sh;
  logic [31:0]        value_c;

  assign hdr_bad = cfg.header_word[31:20] != sefu_pkg::MAGIC_CODE;
  assign expo    = cfg.header_word[15:8];
  assign shift   = cfg.header_word[7:0];
  assign kill    = hdr_bad || (expo == 8'd0);

  assign en       = !out_valid || out_ready;
  assign issue    = head_valid && en;
  assign pop      = issue && (half || !head.two);
  assign token    = half ? head.word[15:0] : head.word[31:16];
  assign tok_last = half ? head.last1 : head.last0;

  // a nonzero token shifted 26 or more always saturates, so 41 bits cover the rest
  assign wide  = {25'd0, token} << shift[4:0];
  assign big_c = (token != 16'd0) && ((shift >= 8'd26) || (wide[40:26] != 15'd0));
  assign sum_c = $signed({2'b00, wide[25:0]}) + 28'(cfg.minimum_mantissa);

  assign neg  = s1_sum[27];
  assign absv = neg ? 28'(-s1_sum) : 28'(s1_sum);

  assign e9     = {1'b0, expo} + {4'd0, s3_p};
  assign norm   = s3_mag << (5'd23 - s3_p);
  assign sub_sh = 5'(expo - 8'd1);
  assign sub    = {8'd0, s3_mag} << sub_sh;

  always_comb begin
    if (kill || s3_mag == 24'd0) begin
      value_c = 32'd0;
    end else if (e9 >= 9'd24) begin
      value_c = {s3_sign, 8'(e9 - 9'd23), norm[22:0]};
    end else begin
      value_c = {s3_sign, sub[30:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_last <= tok_last;
      s1_big  <= big_c;
      s1_sum  <= sum_c;
      s2_last <= s1_last;
      s2_sign <= !s1_big && neg;
      s2_mag  <= (s1_big || absv[27:24] != 4'd0) ? sefu_pkg::MAG_LIMIT : absv[23:0];
      s3_last <= s2_last;
      s3_sign <= s2_sign;
      s3_mag  <= s2_mag;
      s3_p    <= sefu_pkg::msb_index(s2_mag);
      value_bits <= value_c;
      last_value <= s3_last;
      header_bad <= hdr_bad;
      token_bits <= {1'b0, cfg.header_word[19:16]} + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half      <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      if (issue) half <= !pop;
      s1_valid  <= issue;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  half_needs_head: assert property (@(posedge clk) disable iff (rst)
    half |-> head_valid && head.two) else $error("second token without a queued word");

  bad_gives_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && header_bad) |-> value_bits == 32'd0) else $error("bad header with nonzero value");

  pair_pops_on_second: assert property (@(posedge clk) disable iff (rst)
    (pop && head.two) |-> half) else $error("paired word popped after one token");

endmodule

// ===== rtl/shared_exponent_float_unpacker.sv =====
// Top level of the shared exponent float unpacker.
// Usage:
//   Write header_word (index 0), minimum_mantissa (1) and point_count (2) on the
//   cfg channel while the block is idle; any of these writes restarts the block count.
//   cfg_ready is always high.
//   Each item on the input channel is one 32-bit stream word with two tokens,
//   upper token first. Each token gives one result item on the output channel:
//   the IEEE single pattern, a last-of-block flag, the bad-header flag and the
//   decoded token width. The final word of an odd block gives one result;
//   words arriving after the block is complete are taken and dropped.
// Timing:
//   A word enters a 4-deep queue the cycle it is accepted; the back end then
//   issues one token per cycle through a four stage pipeline while the receiver
//   does not stall. A new word can follow before the last has left the pipeline,
//   and each word's tokens share the single output port, one value per cycle.
// Reset clears the configuration, the block count, the queue and the pipeline.
// When the receiver stalls, the pipeline holds; the queue keeps accepting
// words until it is full, then in_ready drops.
module shared_exponent_float_unpacker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] stream_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] value_bits,
  output logic        last_value,
  output logic        header_bad,
  output logic [4:0]  token_bits,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  sefu_pkg::cfg_t   cfg;
  sefu_pkg::entry_t q_entry;
  sefu_pkg::entry_t head;
  logic             q_push;
  logic             q_full;
  logic             head_valid;
  logic             pop;

  sefu_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .stream_word (stream_word),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (q_entry),
    .cfg         (cfg)
  );

  sefu_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (q_full)
  );

  sefu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value_bits (value_bits),
    .last_value (last_value),
    .header_bad (header_bad),
    .token_bits (token_bits)
  );

endmodule
